// ----- design/bfcg_pkg.sv -----
// Shared types and constants of the buffered floppy card glue.
package bfcg_pkg;

   localparam int BUFFER_DEPTH = 512;
   localparam int BUF_ADDR_W   = $clog2(BUFFER_DEPTH);
   localparam int PTR_W        = 9;

   typedef enum logic [1:0] {
      OP_BUS_RD  = 2'd0,
      OP_BUS_WR  = 2'd1,
      OP_DMA_REQ = 2'd2,
      OP_IRQ     = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ACC_NONE    = 3'd0,
      ACC_FIFO_RD = 3'd1,
      ACC_MSR_RD  = 3'd2,
      ACC_FIFO_WR = 3'd3,
      ACC_DMA_RD  = 3'd4,
      ACC_DMA_WR  = 3'd5
   } access_type;

   localparam logic [3:0] OFS_FIFO  = 4'd0;
   localparam logic [3:0] OFS_MSR   = 4'd1;
   localparam logic [3:0] OFS_PTR   = 4'd2;
   localparam logic [3:0] OFS_DATA  = 4'd3;
   localparam logic [3:0] OFS_LOCAL = 4'd4;

   localparam logic [7:0] UNUSED_RDATA = 8'hff;
   localparam logic [7:0] STATUS_RESET = 8'h02;

   localparam int CMD_SELECT_BIT = 2;
   localparam int CMD_MOTOR_BIT  = 3;
   localparam int CMD_IRQ_EN_BIT = 5;
   localparam int CMD_FILL_BIT   = 6;
   localparam int CMD_RESET_BIT  = 7;

   localparam int STS_CHANGE_BIT = 0;
   localparam int STS_IRQ_N_BIT  = 1;
   localparam int STS_READY_BIT  = 6;

   typedef struct packed {
      logic [7:0]  rdata;
      access_type  fdc_access;
      logic [7:0]  fdc_wdata;
      logic        fdc_reset;
      logic        terminal_count;
      logic        slot_irq;
      logic [1:0]  drive_number;
      logic        drive_active;
      logic        motor_off;
      logic        rdata_from_buf;
      logic        wdata_from_buf;
   } stage_type;

endpackage

// ----- design/bfcg_ram.sv -----
// Generic single-port RAM with registered read data.
module bfcg_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 512
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[addr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ----- design/bfcg_ctrl.sv -----
// Card state, beat decode, buffer access and first result stage.
module bfcg_ctrl (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [1:0]                    req_op,
   input  logic [3:0]                    req_offset,
   input  logic [7:0]                    req_wdata,
   input  logic [7:0]                    req_fdc_byte,
   input  logic                          req_line_level,
   input  logic                          req_disk_changed,
   input  logic                          req_drive_ready,
   input  logic                          out_ready,
   output logic                          stage_valid,
   output bfcg_pkg::stage_type           stage,
   output logic                          buf_we,
   output logic                          buf_re,
   output logic [bfcg_pkg::BUF_ADDR_W-1:0] buf_addr,
   output logic [7:0]                    buf_wdata
);
   import bfcg_pkg::*;

   logic [PTR_W-1:0] ptr_ff, ptr_in;
   logic [7:0]       status_ff, status_in;
   logic [7:0]       command_ff, command_in;
   logic [1:0]       drive_ff, drive_in;
   logic             active_ff, active_in;
   logic             irq_ff, irq_in;
   logic             motor_ff, motor_in;
   logic             stage_valid_ff, stage_valid_in;
   stage_type        stage_ff, stage_in;
   logic             accept;
   logic             wr_buf, rd_buf;

   assign req_ready = !stage_valid_ff || out_ready;
   assign accept    = req_valid && req_ready;

   always_comb begin
      ptr_in     = ptr_ff;
      status_in  = status_ff;
      command_in = command_ff;
      drive_in   = drive_ff;
      active_in  = active_ff;
      irq_in     = irq_ff;
      motor_in   = motor_ff;
      wr_buf     = 1'b0;
      rd_buf     = 1'b0;
      buf_wdata  = req_wdata;
      stage_in   = '0;
      stage_in.fdc_access = ACC_NONE;
      unique case (op_type'(req_op))
         OP_BUS_RD: begin
            stage_in.rdata = UNUSED_RDATA;
            unique case (req_offset)
               OFS_FIFO: begin
                  stage_in.rdata      = req_fdc_byte;
                  stage_in.fdc_access = ACC_FIFO_RD;
               end
               OFS_MSR: begin
                  stage_in.rdata      = req_fdc_byte;
                  stage_in.fdc_access = ACC_MSR_RD;
               end
               OFS_PTR: begin
                  stage_in.rdata = ptr_ff[8:1];
               end
               OFS_DATA: begin
                  rd_buf                  = 1'b1;
                  stage_in.rdata_from_buf = 1'b1;
                  ptr_in                  = ptr_ff - 1'b1;
               end
               OFS_LOCAL: begin
                  if (active_ff) begin
                     status_in[STS_CHANGE_BIT] = req_disk_changed;
                     status_in[STS_READY_BIT]  = req_drive_ready;
                  end
                  stage_in.rdata = status_in;
               end
               default: begin
                  stage_in.rdata = UNUSED_RDATA;
               end
            endcase
         end
         OP_BUS_WR: begin
            unique case (req_offset)
               OFS_FIFO: begin
                  stage_in.fdc_access = ACC_FIFO_WR;
                  stage_in.fdc_wdata  = req_wdata;
               end
               OFS_PTR: begin
                  ptr_in = {req_wdata, req_wdata[0]};
               end
               OFS_DATA: begin
                  wr_buf = 1'b1;
                  ptr_in = ptr_ff - 1'b1;
               end
               OFS_LOCAL: begin
                  command_in = req_wdata;
                  if (req_wdata[CMD_SELECT_BIT]) begin
                     drive_in  = req_wdata[1:0];
                     active_in = 1'b1;
                  end
                  if (active_in) begin
                     motor_in = req_wdata[CMD_MOTOR_BIT];
                  end
                  stage_in.fdc_reset = req_wdata[CMD_RESET_BIT];
               end
               default: begin
               end
            endcase
         end
         OP_DMA_REQ: begin
            if (req_line_level) begin
               if (command_ff[CMD_FILL_BIT]) begin
                  stage_in.fdc_access     = ACC_DMA_RD;
                  wr_buf                  = 1'b1;
                  buf_wdata               = req_fdc_byte;
                  stage_in.terminal_count = (ptr_ff == '0);
                  ptr_in                  = ptr_ff - 1'b1;
               end else begin
                  stage_in.fdc_access     = ACC_DMA_WR;
                  rd_buf                  = 1'b1;
                  stage_in.wdata_from_buf = 1'b1;
                  ptr_in                  = ptr_ff + 1'b1;
               end
            end
         end
         OP_IRQ: begin
            if (req_line_level) begin
               status_in[STS_IRQ_N_BIT] = 1'b0;
               if (command_ff[CMD_IRQ_EN_BIT]) begin
                  irq_in = 1'b1;
               end
            end else begin
               status_in[STS_IRQ_N_BIT] = 1'b1;
               irq_in                   = 1'b0;
            end
         end
         default: begin
         end
      endcase
      stage_in.slot_irq     = irq_in;
      stage_in.drive_number = drive_in;
      stage_in.drive_active = active_in;
      stage_in.motor_off    = motor_in;
   end

   always_comb begin
      if (accept) begin
         stage_valid_in = 1'b1;
      end else if (out_ready) begin
         stage_valid_in = 1'b0;
      end else begin
         stage_valid_in = stage_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ptr_ff         <= '0;
         status_ff      <= STATUS_RESET;
         command_ff     <= '0;
         drive_ff       <= '0;
         active_ff      <= 1'b0;
         irq_ff         <= 1'b0;
         motor_ff       <= 1'b0;
         stage_valid_ff <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
         if (accept) begin
            ptr_ff     <= ptr_in;
            status_ff  <= status_in;
            command_ff <= command_in;
            drive_ff   <= drive_in;
            active_ff  <= active_in;
            irq_ff     <= irq_in;
            motor_ff   <= motor_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         stage_ff <= stage_in;
      end
   end

   assign buf_we      = accept && wr_buf;
   assign buf_re      = accept && rd_buf;
   assign buf_addr    = BUF_ADDR_W'(ptr_ff);
   assign stage_valid = stage_valid_ff;
   assign stage       = stage_ff;

endmodule

// ----- design/bfcg_out.sv -----
// Result register that merges buffer read data into the result beat.
module bfcg_out (
   input  logic                clock,
   input  logic                reset,
   input  logic                stage_valid,
   input  bfcg_pkg::stage_type stage,
   input  logic [7:0]          buf_rdata,
   output logic                out_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [7:0]          rsp_rdata,
   output logic [2:0]          rsp_fdc_access,
   output logic [7:0]          rsp_fdc_wdata,
   output logic                rsp_fdc_reset,
   output logic                rsp_terminal_count,
   output logic                rsp_slot_irq,
   output logic [1:0]          rsp_drive_number,
   output logic                rsp_drive_active,
   output logic                rsp_motor_off
);
   import bfcg_pkg::*;

   logic      rsp_valid_ff, rsp_valid_in;
   stage_type rsp_ff, rsp_in;
   logic      take;

   assign out_ready = !rsp_valid_ff || rsp_ready;
   assign take      = stage_valid && out_ready;

   always_comb begin
      rsp_in = stage;
      if (stage.rdata_from_buf) begin
         rsp_in.rdata = buf_rdata;
      end
      if (stage.wdata_from_buf) begin
         rsp_in.fdc_wdata = buf_rdata;
      end
   end

   always_comb begin
      if (take) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_rdata          = rsp_ff.rdata;
   assign rsp_fdc_access     = 3'(rsp_ff.fdc_access);
   assign rsp_fdc_wdata      = rsp_ff.fdc_wdata;
   assign rsp_fdc_reset      = rsp_ff.fdc_reset;
   assign rsp_terminal_count = rsp_ff.terminal_count;
   assign rsp_slot_irq       = rsp_ff.slot_irq;
   assign rsp_drive_number   = rsp_ff.drive_number;
   assign rsp_drive_active   = rsp_ff.drive_active;
   assign rsp_motor_off      = rsp_ff.motor_off;

endmodule

// ----- design/buffered_floppy_card_glue.sv -----
// Top level of the buffered floppy card glue.
// Each request beat is a bus read or write, a DMA request line change or an interrupt line
// change; it yields one response beat via the stage and result registers. A new request
// is accepted every cycle unless the output stalls: the card registers and the sector
// buffer pointer are updated at acceptance, the sector buffer RAM is touched at most once
// through its single port, and its registered read data joins the response in the result
// register. Buffer contents are not cleared by reset, so only written entries may be read.
module buffered_floppy_card_glue (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [1:0] req_op,
   input  logic [3:0] req_offset,
   input  logic [7:0] req_wdata,
   input  logic [7:0] req_fdc_byte,
   input  logic       req_line_level,
   input  logic       req_disk_changed,
   input  logic       req_drive_ready,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_rdata,
   output logic [2:0] rsp_fdc_access,
   output logic [7:0] rsp_fdc_wdata,
   output logic       rsp_fdc_reset,
   output logic       rsp_terminal_count,
   output logic       rsp_slot_irq,
   output logic [1:0] rsp_drive_number,
   output logic       rsp_drive_active,
   output logic       rsp_motor_off
);
   import bfcg_pkg::*;

   logic                  out_ready;
   logic                  stage_valid;
   stage_type             stage;
   logic                  buf_we;
   logic                  buf_re;
   logic [BUF_ADDR_W-1:0] buf_addr;
   logic [7:0]            buf_wdata;
   logic [7:0]            buf_rdata;

   bfcg_ctrl u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_op           (req_op),
      .req_offset       (req_offset),
      .req_wdata        (req_wdata),
      .req_fdc_byte     (req_fdc_byte),
      .req_line_level   (req_line_level),
      .req_disk_changed (req_disk_changed),
      .req_drive_ready  (req_drive_ready),
      .out_ready        (out_ready),
      .stage_valid      (stage_valid),
      .stage            (stage),
      .buf_we           (buf_we),
      .buf_re           (buf_re),
      .buf_addr         (buf_addr),
      .buf_wdata        (buf_wdata)
   );

   bfcg_ram #(
      .WIDTH (8),
      .DEPTH (BUFFER_DEPTH)
   ) u_sector_buffer (
      .clock (clock),
      .we    (buf_we),
      .re    (buf_re),
      .addr  (buf_addr),
      .wdata (buf_wdata),
      .rdata (buf_rdata)
   );

   bfcg_out u_out (
      .clock              (clock),
      .reset              (reset),
      .stage_valid        (stage_valid),
      .stage              (stage),
      .buf_rdata          (buf_rdata),
      .out_ready          (out_ready),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_rdata          (rsp_rdata),
      .rsp_fdc_access     (rsp_fdc_access),
      .rsp_fdc_wdata      (rsp_fdc_wdata),
      .rsp_fdc_reset      (rsp_fdc_reset),
      .rsp_terminal_count (rsp_terminal_count),
      .rsp_slot_irq       (rsp_slot_irq),
      .rsp_drive_number   (rsp_drive_number),
      .rsp_drive_active   (rsp_drive_active),
      .rsp_motor_off      (rsp_motor_off)
   );

endmodule
